@@ rtl/rms_pkg.sv @@
`timescale 1ns / 1ps

package rms_pkg;

   localparam int DEF_COUNT_BITS  = 24;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int FRAC_BITS       = 8;
   localparam int OUT_BITS        = 24;

   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } rms_stat_type;

endpackage

@@ rtl/rms_alu.sv @@
`timescale 1ns / 1ps

module rms_alu import rms_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             op,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH-1:0] res,
   output logic             cout
);

   logic [WIDTH-1:0] b_sel;
   logic             sub;

   assign sub   = (op == ALU_SUB);
   assign b_sel = sub ? ~b : b;
   assign {cout, res} = {1'b0, a} + {1'b0, b_sel} + (WIDTH + 1)'(sub);

endmodule

@@ rtl/rms_core.sv @@
`timescale 1ns / 1ps

module rms_core import rms_pkg::*; #(
   parameter int COUNT_BITS  = DEF_COUNT_BITS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [COUNT_BITS-1:0]                     count,
   input  logic signed [SAMPLE_BITS+COUNT_BITS-1:0]  sum,
   input  logic [2*SAMPLE_BITS-2+COUNT_BITS-1:0]     sqsum,
   output logic [OUT_BITS-1:0]                       mean,
   output logic [OUT_BITS-1:0]                       sigma,
   output rms_stat_type                              stat
);

   localparam int SUMW = SAMPLE_BITS + COUNT_BITS;
   localparam int SQW  = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
   localparam int MAGW = SUMW - 1;
   localparam int PW   = COUNT_BITS + SQW;
   localparam int VW   = PW + 2 * FRAC_BITS;
   localparam int RW   = VW / 2;
   localparam int DW   = MAGW + FRAC_BITS;
   localparam int QW   = (RW > DW) ? RW : DW;
   localparam int AW1  = (PW > RW + 2) ? PW : RW + 2;
   localparam int AW   = (AW1 > DW + 1) ? AW1 : DW + 1;
   localparam int CNTW = $clog2(QW + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL1 = 3'd1;
   localparam logic [2:0] S_MUL2 = 3'd2;
   localparam logic [2:0] S_VAR  = 3'd3;
   localparam logic [2:0] S_SQRT = 3'd4;
   localparam logic [2:0] S_DIVS = 3'd5;
   localparam logic [2:0] S_DIVM = 3'd6;
   localparam logic [2:0] S_FIX  = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic [MAGW-1:0]       mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [SQW-1:0]        sq_ff, sq_in;
   logic [AW-1:0]         acc_ff, acc_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [VW-1:0]         bits_ff, bits_in;
   logic [QW-1:0]         q_ff, q_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [OUT_BITS-1:0]   mean_ff, mean_in;
   logic [OUT_BITS-1:0]   sigma_ff, sigma_in;

   logic                  alu_op;
   logic [AW-1:0]         alu_a, alu_b, alu_res;
   logic                  alu_cout;
   logic [AW-1:0]         acc_sh, rem_sqrt, rem_div;
   logic                  last;
   logic [QW-1:0]         q_step;
   logic [DW:0]           mean_full;
   logic signed [SUMW-1:0] sum_neg;

   rms_alu #(.WIDTH(AW)) u_alu (
      .op   (alu_op),
      .a    (alu_a),
      .b    (alu_b),
      .res  (alu_res),
      .cout (alu_cout)
   );

   assign acc_sh   = {acc_ff[AW-2:0], 1'b0};
   assign rem_sqrt = {acc_ff[AW-3:0], bits_ff[VW-1:VW-2]};
   assign rem_div  = {acc_ff[AW-2:0], bits_ff[VW-1]};
   assign last     = (cnt_ff == CNTW'(1));
   assign q_step   = {q_ff[QW-2:0], alu_cout};
   assign sum_neg  = -sum;

   always_comb begin
      alu_op = ALU_ADD;
      alu_a  = '0;
      alu_b  = '0;
      case (state_ff)
         S_MUL1: begin
            alu_a = acc_sh;
            alu_b = bits_ff[VW-1] ? AW'(sq_ff) : '0;
         end
         S_MUL2: begin
            alu_a = acc_sh;
            alu_b = bits_ff[VW-1] ? AW'(mag_ff) : '0;
         end
         S_VAR: begin
            alu_op = ALU_SUB;
            alu_a  = AW'(prod_ff);
            alu_b  = acc_ff;
         end
         S_SQRT: begin
            alu_op = ALU_SUB;
            alu_a  = rem_sqrt;
            alu_b  = AW'({q_ff, 2'b01});
         end
         S_DIVS, S_DIVM: begin
            alu_op = ALU_SUB;
            alu_a  = rem_div;
            alu_b  = AW'(n_ff);
         end
         S_FIX: begin
            alu_op = ALU_SUB;
            alu_b  = AW'(q_ff[DW-1:0]);
         end
         default: begin
            alu_op = ALU_ADD;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      n_in      = n_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      sq_in     = sq_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      bits_in   = bits_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      mean_in   = mean_ff;
      sigma_in  = sigma_ff;
      mean_full = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in     = count;
               mag_in   = sum[SUMW-1] ? MAGW'(sum_neg) : MAGW'(sum);
               neg_in   = sum[SUMW-1];
               sq_in    = sqsum;
               acc_in   = '0;
               bits_in  = VW'(count) << (VW - COUNT_BITS);
               cnt_in   = CNTW'(COUNT_BITS);
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            acc_in  = alu_res;
            bits_in = bits_ff << 1;
            cnt_in  = cnt_ff - CNTW'(1);
            if (last) begin
               prod_in  = alu_res[PW-1:0];
               acc_in   = '0;
               bits_in  = VW'(mag_ff) << (VW - MAGW);
               cnt_in   = CNTW'(MAGW);
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            acc_in  = alu_res;
            bits_in = bits_ff << 1;
            cnt_in  = cnt_ff - CNTW'(1);
            if (last) begin
               state_in = S_VAR;
            end
         end
         S_VAR: begin
            bits_in  = alu_cout ? (VW'(alu_res[PW-1:0]) << (2 * FRAC_BITS)) : '0;
            acc_in   = '0;
            q_in     = '0;
            cnt_in   = CNTW'(RW);
            state_in = S_SQRT;
         end
         S_SQRT: begin
            acc_in  = alu_cout ? alu_res : rem_sqrt;
            q_in    = q_step;
            bits_in = bits_ff << 2;
            cnt_in  = cnt_ff - CNTW'(1);
            if (last) begin
               acc_in   = '0;
               q_in     = '0;
               bits_in  = VW'(q_step) << (VW - RW);
               cnt_in   = CNTW'(RW);
               state_in = S_DIVS;
            end
         end
         S_DIVS: begin
            acc_in  = alu_cout ? alu_res : rem_div;
            q_in    = q_step;
            bits_in = bits_ff << 1;
            cnt_in  = cnt_ff - CNTW'(1);
            if (last) begin
               sigma_in = OUT_BITS'(q_step);
               acc_in   = '0;
               q_in     = '0;
               bits_in  = VW'({mag_ff, {FRAC_BITS{1'b0}}}) << (VW - DW);
               cnt_in   = CNTW'(DW);
               state_in = S_DIVM;
            end
         end
         S_DIVM: begin
            acc_in  = alu_cout ? alu_res : rem_div;
            q_in    = q_step;
            bits_in = bits_ff << 1;
            cnt_in  = cnt_ff - CNTW'(1);
            if (last) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if (!neg_ff) begin
               mean_full = {1'b0, q_ff[DW-1:0]};
            end else if (acc_ff != '0) begin
               mean_full = ~{1'b0, q_ff[DW-1:0]};
            end else begin
               mean_full = alu_res[DW:0];
            end
            mean_in  = OUT_BITS'(signed'(mean_full));
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      sq_ff    <= sq_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      bits_ff  <= bits_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      mean_ff  <= mean_in;
      sigma_ff <= sigma_in;
   end

   assign mean      = mean_ff;
   assign sigma     = sigma_ff;
   assign stat.busy = (state_ff != S_IDLE);
   assign stat.done = done_ff;

endmodule

@@ rtl/running_mean_sigma.sv @@
`timescale 1ns / 1ps

// Running count, mean and population standard deviation of signed samples,
// exact in integers. Each transfer adds one sample (restart clears the sums
// first) and yields one result; once the count is full, samples are dropped
// and saturated is set. Each result is worked out by the single shared
// add/subtract unit stepping one bit at a time through two multiplies, a
// square root and two divides; req_ready stays low from the transfer until
// the result is loaded into the response register.

module running_mean_sigma import rms_pkg::*; #(
   parameter int COUNT_BITS  = DEF_COUNT_BITS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [OUT_BITS-1:0]           rsp_count,
   output logic signed [OUT_BITS-1:0]    rsp_mean,
   output logic [OUT_BITS-1:0]           rsp_sigma,
   output logic                          rsp_saturated
);

   localparam int SUMW = SAMPLE_BITS + COUNT_BITS;
   localparam int SQW  = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
   localparam int SQ1W = 2 * SAMPLE_BITS - 1;

   localparam logic [2:0] T_IDLE = 3'd0;
   localparam logic [2:0] T_SQ   = 3'd1;
   localparam logic [2:0] T_ACC  = 3'd2;
   localparam logic [2:0] T_RUN  = 3'd3;
   localparam logic [2:0] T_HOLD = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] samp_ff, samp_in;
   logic                         restart_ff, restart_in;
   logic [SQ1W-1:0]              square_ff, square_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [SUMW-1:0]       sum_ff, sum_in;
   logic [SQW-1:0]               sqsum_ff, sqsum_in;
   logic                         sat_ff, sat_in;
   logic                         start_ff, start_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]          rsp_count_ff, rsp_count_in;
   logic [OUT_BITS-1:0]          rsp_mean_ff, rsp_mean_in;
   logic [OUT_BITS-1:0]          rsp_sigma_ff, rsp_sigma_in;
   logic                         rsp_sat_ff, rsp_sat_in;

   logic [SAMPLE_BITS-1:0]       samp_mag;
   logic [2*SAMPLE_BITS-1:0]     samp_prod;
   logic [OUT_BITS-1:0]          core_mean, core_sigma;
   rms_stat_type                 core_stat;
   logic                         out_free;
   logic                         load;

   rms_core #(
      .COUNT_BITS  (COUNT_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .count (count_ff),
      .sum   (sum_ff),
      .sqsum (sqsum_ff),
      .mean  (core_mean),
      .sigma (core_sigma),
      .stat  (core_stat)
   );

   assign samp_mag  = samp_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samp_ff) : samp_ff;
   assign samp_prod = samp_mag * samp_mag;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load      = out_free &&
                      ((state_ff == T_RUN && core_stat.done) || state_ff == T_HOLD);

   always_comb begin
      state_in     = state_ff;
      samp_in      = samp_ff;
      restart_in   = restart_ff;
      square_in    = square_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sqsum_in     = sqsum_ff;
      sat_in       = sat_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_sigma_in = rsp_sigma_ff;
      rsp_sat_in   = rsp_sat_ff;
      case (state_ff)
         T_IDLE: begin
            if (req_valid) begin
               samp_in    = req_sample;
               restart_in = req_restart;
               state_in   = T_SQ;
            end
         end
         T_SQ: begin
            square_in = samp_prod[SQ1W-1:0];
            if (restart_ff) begin
               count_in = '0;
               sum_in   = '0;
               sqsum_in = '0;
            end
            state_in = T_ACC;
         end
         T_ACC: begin
            if (count_ff == '1) begin
               sat_in = 1'b1;
            end else begin
               sat_in   = 1'b0;
               count_in = count_ff + COUNT_BITS'(1);
               sum_in   = sum_ff + SUMW'(samp_ff);
               sqsum_in = sqsum_ff + SQW'(square_ff);
            end
            start_in = 1'b1;
            state_in = T_RUN;
         end
         T_RUN: begin
            if (core_stat.done) begin
               state_in = load ? T_IDLE : T_HOLD;
            end
         end
         T_HOLD: begin
            if (load) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = OUT_BITS'(count_ff);
         rsp_mean_in  = core_mean;
         rsp_sigma_in = core_sigma;
         rsp_sat_in   = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         sat_ff       <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
         sat_ff       <= sat_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff      <= samp_in;
      restart_ff   <= restart_in;
      square_ff    <= square_in;
      rsp_count_ff <= rsp_count_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_sigma_ff <= rsp_sigma_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_ready     = (state_ff == T_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_mean      = rsp_mean_ff;
   assign rsp_sigma     = rsp_sigma_ff;
   assign rsp_saturated = rsp_sat_ff;

`ifndef ASSERT_OFF
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      core_stat.done |-> state_ff == T_RUN)
      else $error("core done outside run");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> !core_stat.busy)
      else $error("start while core busy");

   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_RUN && sat_ff) |-> count_ff == '1)
      else $error("saturated with count not full");
`endif

endmodule
